>>> rtl/hiwm_pkg.sv
// ----------------------------------------------------------------------------
// hiwm_pkg
// Shared types and constants for the homography inverse warp mapper.
// ----------------------------------------------------------------------------
package hiwm_pkg;

   localparam int COEF_W  = 48;
   localparam int COORD_W = 14;
   localparam int OUT_W   = 10;
   localparam int PROD_W  = COEF_W + COORD_W;
   localparam int ACC_W   = 64;
   localparam int QUO_W   = 13;
   localparam int CMP_W   = ACC_W + QUO_W;
   localparam int NUM_COEF = 8;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] IDX_A = 3'd0;
   localparam logic [IDX_W-1:0] IDX_B = 3'd1;
   localparam logic [IDX_W-1:0] IDX_C = 3'd2;
   localparam logic [IDX_W-1:0] IDX_D = 3'd3;
   localparam logic [IDX_W-1:0] IDX_E = 3'd4;
   localparam logic [IDX_W-1:0] IDX_F = 3'd5;
   localparam logic [IDX_W-1:0] IDX_G = 3'd6;
   localparam logic [IDX_W-1:0] IDX_H = 3'd7;

   localparam logic [COEF_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
   localparam logic [ACC_W-1:0]  ONE_ACC = 64'h0000_0001_0000_0000;

   typedef logic [COEF_W-1:0] coef_type [NUM_COEF];

   // one quotient lane in flight
   typedef struct packed {
      logic [ACC_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   // one beat in the divider pipeline
   typedef struct packed {
      logic             valid;
      logic [ACC_W-1:0] dvs;
      lane_type         lx;
      lane_type         ly;
   } div_item_type;

endpackage

>>> rtl/hiwm_front.sv
// ----------------------------------------------------------------------------
// hiwm_front
// Multiply, sum and take magnitudes: turns a coordinate into two dividend
// lanes and a divisor, with the out-of-range test already done. Four stages.
// ----------------------------------------------------------------------------
module hiwm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  hiwm_pkg::coef_type             coef,
   input  logic                           in_valid,
   input  logic [hiwm_pkg::COORD_W-1:0]   in_x,
   input  logic [hiwm_pkg::COORD_W-1:0]   in_y,
   output hiwm_pkg::div_item_type         out_item
);

   localparam int PW = hiwm_pkg::PROD_W;
   localparam int AW = hiwm_pkg::ACC_W;
   localparam int CW = hiwm_pkg::CMP_W;
   localparam int QW = hiwm_pkg::QUO_W;

   // stage 1: products
   logic                 v1_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pd_ff, pe_ff, pg_ff, ph_ff;
   logic [hiwm_pkg::COEF_W-1:0] c_ff, f_ff;

   // stage 2: sums
   logic          v2_ff;
   logic [AW-1:0] u_ff, vv_ff, w_ff;

   // stage 3: magnitudes
   logic          v3_ff;
   logic [AW-1:0] mu_ff, mv_ff, mw_ff;
   logic          nx_ff, ny_ff;

   // stage 4: range test
   hiwm_pkg::div_item_type item_ff, item_in;

   function automatic logic [AW-1:0] sx_prod(input logic [PW-1:0] p);
      return {{(AW-PW){p[PW-1]}}, p};
   endfunction

   function automatic logic [AW-1:0] sx_coef(input logic [hiwm_pkg::COEF_W-1:0] c);
      return {{(AW-hiwm_pkg::COEF_W){c[hiwm_pkg::COEF_W-1]}}, c};
   endfunction

   function automatic logic [AW-1:0] mag(input logic [AW-1:0] a);
      return a[AW-1] ? (~a + AW'(1)) : a;
   endfunction

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // multiply and sum
   always_ff @(posedge clock) begin
      pa_ff <= $signed(coef[hiwm_pkg::IDX_A]) * $signed(in_x);
      pb_ff <= $signed(coef[hiwm_pkg::IDX_B]) * $signed(in_y);
      pd_ff <= $signed(coef[hiwm_pkg::IDX_D]) * $signed(in_x);
      pe_ff <= $signed(coef[hiwm_pkg::IDX_E]) * $signed(in_y);
      pg_ff <= $signed(coef[hiwm_pkg::IDX_G]) * $signed(in_x);
      ph_ff <= $signed(coef[hiwm_pkg::IDX_H]) * $signed(in_y);
      c_ff  <= coef[hiwm_pkg::IDX_C];
      f_ff  <= coef[hiwm_pkg::IDX_F];
      u_ff  <= sx_prod(pa_ff) + sx_prod(pb_ff) + sx_coef(c_ff);
      vv_ff <= sx_prod(pd_ff) + sx_prod(pe_ff) + sx_coef(f_ff);
      w_ff  <= sx_prod(pg_ff) + sx_prod(ph_ff) + hiwm_pkg::ONE_ACC;
      mu_ff <= mag(u_ff);
      mv_ff <= mag(vv_ff);
      mw_ff <= mag(w_ff);
      nx_ff <= u_ff[AW-1] ^ w_ff[AW-1];
      ny_ff <= vv_ff[AW-1] ^ w_ff[AW-1];
   end

   // flag quotients that cannot fit; a zero divisor always flags
   always_comb begin
      item_in.valid  = v3_ff;
      item_in.dvs    = mw_ff;
      item_in.lx.rem = mu_ff;
      item_in.lx.quo = '0;
      item_in.lx.neg = nx_ff;
      item_in.lx.ovf = {QW'(0), mu_ff} >= ({QW'(0), mw_ff} << QW);
      item_in.ly.rem = mv_ff;
      item_in.ly.quo = '0;
      item_in.ly.neg = ny_ff;
      item_in.ly.ovf = {QW'(0), mv_ff} >= (CW'({QW'(0), mw_ff}) << QW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.dvs <= item_in.dvs;
      item_ff.lx  <= item_in.lx;
      item_ff.ly  <= item_in.ly;
   end

   assign out_item = item_ff;

endmodule

>>> rtl/hiwm_div_stage.sv
// ----------------------------------------------------------------------------
// hiwm_div_stage
// One restoring division step: resolves quotient bit BIT of both lanes.
// ----------------------------------------------------------------------------
module hiwm_div_stage #(
   parameter int BIT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hiwm_pkg::div_item_type  in_item,
   output hiwm_pkg::div_item_type  out_item
);

   localparam int AW = hiwm_pkg::ACC_W;
   localparam int CW = hiwm_pkg::CMP_W;

   hiwm_pkg::div_item_type item_ff, item_in;
   logic [CW-1:0] shd;
   logic [CW-1:0] tx, ty;

   // compare each remainder with the shifted divisor and subtract on fit
   always_comb begin
      shd = CW'(in_item.dvs) << BIT;
      tx  = CW'(in_item.lx.rem);
      ty  = CW'(in_item.ly.rem);
      item_in = in_item;
      if (tx >= shd) begin
         item_in.lx.rem      = AW'(tx - shd);
         item_in.lx.quo[BIT] = 1'b1;
      end
      if (ty >= shd) begin
         item_in.ly.rem      = AW'(ty - shd);
         item_in.ly.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.dvs <= item_in.dvs;
      item_ff.lx  <= item_in.lx;
      item_ff.ly  <= item_in.ly;
   end

   assign out_item = item_ff;

endmodule

>>> rtl/homography_inverse_warp_mapper_unit.sv
// ----------------------------------------------------------------------------
// homography_inverse_warp_mapper_unit
// Maps output pixel coordinates to source coordinates through a 3x3
// projective inverse homography with the corner element fixed at one.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_out_x / req_out_y and raise start; a beat is taken at each
//   clock edge with start high (busy stays low, the block never refuses).
//   Each beat yields one result, shown for one cycle with rsp_valid high:
//   rsp_src_x, rsp_src_y and rsp_inside_res (coordinates zero when outside).
//   A beat passes through one multiply stage, one sum stage, one magnitude
//   stage, one range-test stage, thirteen quotient-bit stages (one restoring
//   subtract per bit) and the output register. Throughput is one beat per
//   cycle, set by the fully pipelined divider.
//   Coefficients are written on the csr port (index 0..7 = a..h, Q16.32)
//   while no beat is in flight. Reset loads the identity mapping and empties
//   the pipeline. The receiver cannot stall, so nothing is ever held.
// ----------------------------------------------------------------------------
module homography_inverse_warp_mapper_unit #(
   parameter int SRC_WIDTH  = 1024,
   parameter int SRC_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [hiwm_pkg::COORD_W-1:0]    req_out_x,
   input  logic [hiwm_pkg::COORD_W-1:0]    req_out_y,
   output logic                            rsp_valid,
   output logic [hiwm_pkg::OUT_W-1:0]      rsp_src_x,
   output logic [hiwm_pkg::OUT_W-1:0]      rsp_src_y,
   output logic                            rsp_inside_res,
   input  logic                            csr_we,
   input  logic [hiwm_pkg::IDX_W-1:0]      csr_index,
   input  logic [hiwm_pkg::COEF_W-1:0]     csr_wdata
);

   localparam int QW = hiwm_pkg::QUO_W;
   localparam int CQ = QW + 1;

   hiwm_pkg::coef_type      coef_ff;
   hiwm_pkg::div_item_type  pipe [QW+1];

   logic                        valid_ff;
   logic [hiwm_pkg::OUT_W-1:0]  sx_ff, sy_ff;
   logic                        inside_ff;
   logic                        in_x, in_y;
   hiwm_pkg::div_item_type      last;

   assign busy = 1'b0;

   // hold coefficients; reset to identity
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hiwm_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[hiwm_pkg::IDX_A] <= hiwm_pkg::ONE_Q32;
         coef_ff[hiwm_pkg::IDX_E] <= hiwm_pkg::ONE_Q32;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   hiwm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .coef     (coef_ff),
      .in_valid (start),
      .in_x     (req_out_x),
      .in_y     (req_out_y),
      .out_item (pipe[0])
   );

   // quotient bits, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_div
      hiwm_div_stage #(.BIT(QW - 1 - k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_item  (pipe[k]),
         .out_item (pipe[k+1])
      );
   end

   assign last = pipe[QW];

   // a negative quotient is inside only when it truncates to zero
   always_comb begin
      in_x = !last.lx.ovf && (!last.lx.neg || last.lx.quo == '0)
             && ({1'b0, last.lx.quo} < CQ'(SRC_WIDTH));
      in_y = !last.ly.ovf && (!last.ly.neg || last.ly.quo == '0)
             && ({1'b0, last.ly.quo} < CQ'(SRC_HEIGHT));
   end

   // register the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
      inside_ff <= in_x && in_y;
      sx_ff     <= (in_x && in_y) ? last.lx.quo[hiwm_pkg::OUT_W-1:0] : '0;
      sy_ff     <= (in_x && in_y) ? last.ly.quo[hiwm_pkg::OUT_W-1:0] : '0;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_src_x      = sx_ff;
   assign rsp_src_y      = sy_ff;
   assign rsp_inside_res = inside_ff;

endmodule
